### src/chm_pkg.sv
// chm_pkg: shared constants and types for the chained hash map.
// No dependencies.
`default_nettype none
package chm_pkg;
  localparam int unsigned MaxBuckets  = 256;
  localparam int unsigned PoolEntries = 256;
  localparam int unsigned BktW  = $clog2(MaxBuckets);
  localparam int unsigned NodeW = $clog2(PoolEntries);
  localparam int unsigned LinkW = NodeW + 1;
  localparam int unsigned CntW  = $clog2(PoolEntries + 1);
  localparam int unsigned CfgW  = 9;
  localparam int unsigned KeyW  = 31;
  localparam int unsigned ValW  = 32;

  localparam logic [LinkW-1:0] NilNode = LinkW'(PoolEntries);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_DUP      = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [BktW-1:0] bucket;
  } cmd_t;
endpackage
`default_nettype wire

### src/chm_ram.sv
// chm_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`default_nettype none
module chm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/chm_front.sv
// chm_front: accepts items and computes the bucket (key mod clamped bucket
// count, 1..256), one bit per cycle by restoring reduction. Uses chm_pkg.
`default_nettype none
module chm_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [chm_pkg::CfgW-1:0] bucket_count_q_i,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic [1:0]               op_i,
  input  wire logic [chm_pkg::KeyW-1:0] key_i,
  input  wire logic [chm_pkg::ValW-1:0] value_i,
  output logic                          cmd_valid_o,
  input  wire logic                     cmd_ready_i,
  output chm_pkg::cmd_t                 cmd_o
);
  localparam int unsigned CW = $clog2(chm_pkg::KeyW + 1);
  logic                     busy_q, done_q;
  logic [CW-1:0]            cnt_q;
  logic [chm_pkg::KeyW-1:0] key_q;
  logic [chm_pkg::ValW-1:0] val_q;
  logic [1:0]               op_q;
  logic [chm_pkg::CfgW-1:0] rem_q, div_q;
  logic [chm_pkg::CfgW:0]   trial;
  logic [chm_pkg::CfgW-1:0] divn;

  assign ready_o = !busy_q && !done_q;
  always_comb begin
    divn = bucket_count_q_i;
    if (divn == '0) divn = chm_pkg::CfgW'(1);
    if (divn > chm_pkg::CfgW'(chm_pkg::MaxBuckets)) divn = chm_pkg::CfgW'(chm_pkg::MaxBuckets);
  end
  assign trial = {rem_q, key_q[chm_pkg::KeyW-1]} - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (valid_i && ready_o) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(chm_pkg::KeyW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (done_q && cmd_ready_i) begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      key_q <= key_i;
      val_q <= value_i;
      op_q  <= op_i;
      rem_q <= '0;
      div_q <= divn;
    end else if (busy_q) begin
      key_q <= {key_q[chm_pkg::KeyW-2:0], 1'b0};
      if (!trial[chm_pkg::CfgW]) rem_q <= trial[chm_pkg::CfgW-1:0];
      else rem_q <= {rem_q[chm_pkg::CfgW-2:0], key_q[chm_pkg::KeyW-1]};
    end
  end

  logic [chm_pkg::KeyW-1:0] key_keep_q;
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) key_keep_q <= key_i;
  end

  assign cmd_valid_o  = done_q;
  assign cmd_o.op     = op_q;
  assign cmd_o.key    = key_keep_q;
  assign cmd_o.value  = val_q;
  assign cmd_o.bucket = rem_q[chm_pkg::BktW-1:0];
endmodule
`default_nettype wire

### src/chm_queue.sv
// chm_queue: two-entry command queue between front and back. Uses chm_pkg.
`default_nettype none
module chm_queue (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  chm_pkg::cmd_t in_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output chm_pkg::cmd_t out_o
);
  chm_pkg::cmd_t ent_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;
  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o       = ent_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= in_i;
  end
endmodule
`default_nettype wire

### src/chm_back.sv
// chm_back: walks a bucket chain and carries out insert, lookup or remove.
// Uses chm_pkg and chm_ram for bucket heads, node pool and free stack.
`default_nettype none
module chm_back (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cmd_valid_i,
  output logic        cmd_ready_o,
  input  chm_pkg::cmd_t cmd_i,
  output logic        valid_o,
  input  wire logic   ready_i,
  output logic [1:0]  status_o,
  output logic [chm_pkg::ValW-1:0] found_value_o,
  output logic [chm_pkg::CntW-1:0] entry_total_o,
  output logic        clearing_o
);
  localparam int unsigned NW = chm_pkg::NodeW;
  localparam int unsigned LW = chm_pkg::LinkW;
  localparam int unsigned BW = chm_pkg::BktW;
  localparam int unsigned CW = chm_pkg::CntW;
  localparam int unsigned NodeDW = chm_pkg::KeyW + chm_pkg::ValW + LW;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_NODE  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  st_q, st_d;
  chm_pkg::cmd_t cmd_q;
  logic [BW-1:0] clr_q;
  logic [LW-1:0] cur_q, prev_q;
  logic [CW-1:0] steps_q, free_top_q, mark_q, count_q;
  logic [1:0]    stat_q;
  logic [chm_pkg::ValW-1:0] fv_q;

  // The predecessor rewrite needs the predecessor's key and value; keep them.
  logic [chm_pkg::KeyW-1:0] pk_q;
  logic [chm_pkg::ValW-1:0] pv_q;

  // RAM ports
  logic            h_we;  logic [BW-1:0] h_wa, h_ra; logic [LW-1:0] h_wd; logic [LW-1:0] h_rd;
  logic            n_we;  logic [NW-1:0] n_wa, n_ra; logic [NodeDW-1:0] n_wd, n_rd;
  logic            f_we;  logic [NW-1:0] f_wa, f_ra; logic [NW-1:0] f_wd, f_rd;

  // head read is issued as the command is taken, so it is ready in S_HEAD
  assign h_ra = (st_q == S_IDLE) ? cmd_i.bucket : cmd_q.bucket;

  chm_ram #(.Width(LW), .Depth(chm_pkg::MaxBuckets)) u_head (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd),
    .raddr_i(h_ra), .rdata_o(h_rd));
  chm_ram #(.Width(NodeDW), .Depth(chm_pkg::PoolEntries)) u_node (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd),
    .raddr_i(n_ra), .rdata_o(n_rd));
  chm_ram #(.Width(NW), .Depth(chm_pkg::PoolEntries)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd),
    .raddr_i(f_ra), .rdata_o(f_rd));

  logic [chm_pkg::KeyW-1:0] n_key;
  logic [chm_pkg::ValW-1:0] n_val;
  logic [LW-1:0]            n_link;
  assign {n_key, n_val, n_link} = n_rd;

  logic hit;
  assign hit = n_key == cmd_q.key;

  logic [NW-1:0] fresh;
  logic          have_free, have_mark;
  assign have_free = free_top_q != '0;
  assign have_mark = mark_q < CW'(chm_pkg::PoolEntries);
  assign f_ra = NW'(free_top_q - 1'b1);

  always_comb begin
    st_d = st_q;
    h_we = 1'b0; h_wa = cmd_q.bucket; h_wd = chm_pkg::NilNode;
    n_we = 1'b0; n_wa = cur_q[NW-1:0]; n_wd = '0;
    n_ra = cur_q[NW-1:0];
    f_we = 1'b0; f_wa = free_top_q[NW-1:0]; f_wd = cur_q[NW-1:0];
    fresh = have_free ? f_rd : mark_q[NW-1:0];
    case (st_q)
      S_CLR: begin
        h_we = 1'b1; h_wa = clr_q;
        if (clr_q == BW'(chm_pkg::MaxBuckets - 1)) st_d = S_IDLE;
      end
      S_IDLE: if (cmd_valid_i) st_d = S_HEAD;
      S_HEAD: st_d = S_NODE;
      S_NODE: st_d = S_CHECK;
      S_CHECK: begin
        if (cur_q[LW-1] || steps_q == CW'(chm_pkg::PoolEntries)) begin
          if (cmd_q.op == chm_pkg::OP_INSERT && (have_free || have_mark)) begin
            n_we = 1'b1; n_wa = fresh;
            n_wd = {cmd_q.key, cmd_q.value, h_rd};
            h_we = 1'b1; h_wd = {1'b0, fresh};
          end
          st_d = S_OUT;
        end else if (hit) begin
          if (cmd_q.op == chm_pkg::OP_REMOVE) begin
            if (prev_q[LW-1]) begin
              h_we = 1'b1; h_wd = n_link;
            end else begin
              n_we = 1'b1; n_wa = prev_q[NW-1:0];
              n_wd = {pk_q, pv_q, n_link};
            end
            st_d = S_FREE;
          end else begin
            st_d = S_OUT;
          end
        end else begin
          st_d = S_NODE;
        end
      end
      S_FREE: begin
        f_we = free_top_q < CW'(chm_pkg::PoolEntries);
        st_d = S_OUT;
      end
      S_OUT: if (ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0;
      free_top_q <= '0; mark_q <= '0; count_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (st_q == S_CHECK && (cur_q[LW-1] || steps_q == CW'(chm_pkg::PoolEntries))
          && cmd_q.op == chm_pkg::OP_INSERT) begin
        if (have_free) begin
          free_top_q <= free_top_q - 1'b1; count_q <= count_q + 1'b1;
        end else if (have_mark) begin
          mark_q <= mark_q + 1'b1; count_q <= count_q + 1'b1;
        end
      end
      if (st_q == S_FREE) begin
        if (free_top_q < CW'(chm_pkg::PoolEntries)) free_top_q <= free_top_q + 1'b1;
        if (count_q != '0) count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (cmd_valid_i) begin
        cmd_q <= cmd_i; prev_q <= chm_pkg::NilNode; steps_q <= '0;
        stat_q <= chm_pkg::ST_NOTFOUND; fv_q <= '0;
      end
      S_HEAD: cur_q <= h_rd;
      S_CHECK: begin
        if (cur_q[LW-1] || steps_q == CW'(chm_pkg::PoolEntries)) begin
          if (cmd_q.op == chm_pkg::OP_INSERT)
            stat_q <= (have_free || have_mark) ? chm_pkg::ST_OK : chm_pkg::ST_FULL;
        end else if (hit) begin
          if (cmd_q.op == chm_pkg::OP_INSERT) begin
            stat_q <= chm_pkg::ST_DUP; fv_q <= n_val;
          end else if (cmd_q.op == chm_pkg::OP_LOOKUP || cmd_q.op == chm_pkg::OP_REMOVE) begin
            stat_q <= chm_pkg::ST_OK; fv_q <= n_val;
          end
        end else begin
          prev_q <= cur_q; cur_q <= n_link; steps_q <= steps_q + 1'b1;
          pk_q <= n_key; pv_q <= n_val;
        end
      end
      default: ;
    endcase
  end

  assign cmd_ready_o   = st_q == S_IDLE;
  assign valid_o       = st_q == S_OUT;
  assign status_o      = stat_q;
  assign found_value_o = fv_q;
  assign entry_total_o = count_q;
  assign clearing_o    = st_q == S_CLR;
endmodule
`default_nettype wire

### src/chained_hash_map.sv
// chained_hash_map: top level; front (bucket modulo), queue, back (chain walk).
// Uses chm_pkg, chm_front, chm_queue, chm_back.
//
// Input channel valid_i/ready_o carries op_i, key_i, value_i; output channel
// valid_o/ready_i carries status_o, found_value_o, entry_total_o. One result
// per transaction. bucket_count is written with cfg_we_i/cfg_data_i; the user
// must do so only while idle, the block does not enforce this.
// Front: key mod bucket_count, one quotient bit per cycle; ready_o drops after
// each accepted transaction until the front hands it to the queue.
// Back: each command passes take, head read, node read, check and result;
// each chain node stepped past adds another node read and check, and a
// remove adds a free-stack push. The front takes no new transaction until
// it has handed on the last, so it sets the pace unless the chain walks make
// the back slower. After reset the back clears the 256 bucket heads, one per
// cycle; transactions wait in the front and the queue meanwhile. While
// ready_i is low the back holds its result, the two-entry queue fills, the
// front holds its finished transaction and ready_o stays low (at most 4 in
// flight).
`default_nettype none
module chained_hash_map (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [30:0] key_i,
  input  wire logic [31:0] value_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      found_value_o,
  output logic [8:0]       entry_total_o,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_data_i
);
  logic [chm_pkg::CfgW-1:0] bucket_count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bucket_count_q <= chm_pkg::CfgW'(2);
    else if (cfg_we_i) bucket_count_q <= cfg_data_i;
  end

  logic f_v, f_r, q_v, q_r, clearing;
  chm_pkg::cmd_t f_cmd, q_cmd;

  chm_front u_front (
    .clk_i, .rst_ni, .bucket_count_q_i(bucket_count_q),
    .valid_i, .ready_o, .op_i, .key_i, .value_i,
    .cmd_valid_o(f_v), .cmd_ready_i(f_r), .cmd_o(f_cmd));
  chm_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_v), .in_ready_o(f_r), .in_i(f_cmd),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(q_cmd));
  chm_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_v), .cmd_ready_o(q_r), .cmd_i(q_cmd),
    .valid_o, .ready_i, .status_o, .found_value_o, .entry_total_o,
    .clearing_o(clearing));

`ifndef SYNTH
  a_no_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !valid_o) else $error("result during clear");
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_total_o <= 9'd256) else $error("entry total overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(status_o)) else $error("result dropped");
`endif
endmodule
`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking bench for chained_hash_map (directed, rehash, pool fill, random).
// Depends on chm_pkg and chained_hash_map; keeps its own model of the hash table.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] found;
    logic [8:0]  total;
  } map_result_t;

  typedef struct {
    chm_pkg::op_e op;
    logic [30:0]  key;
    logic [31:0]  value;
    logic         typed;
    map_result_t  res;
  } map_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic [1:0] op_i = '0;
  logic [30:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [1:0] status_o;
  logic [31:0] found_value_o;
  logic [8:0] entry_total_o;
  logic cfg_we_i = 1'b0;
  logic [8:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  chained_hash_map dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .op_i, .key_i, .value_i,
    .valid_o, .ready_i, .status_o, .found_value_o, .entry_total_o,
    .cfg_we_i, .cfg_data_i
  );

  // model state
  logic [8:0]  head_q [chm_pkg::MaxBuckets];
  logic [30:0] nkey_q [chm_pkg::PoolEntries];
  logic [31:0] nval_q [chm_pkg::PoolEntries];
  logic [8:0]  nlink_q [chm_pkg::PoolEntries];
  logic [8:0]  free_q [chm_pkg::PoolEntries];
  int unsigned free_top, fresh_mark, stored, chains;
  logic [8:0]  bucket_cfg;

  map_result_t pending_q[$];
  map_result_t typed_q[$];
  logic        typed_flag_q[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;

  function automatic map_result_t map_apply(chm_pkg::op_e op, logic [30:0] key,
                                            logic [31:0] val);
    map_result_t r;
    int unsigned bkt, n, p, steps, fresh;
    if (bucket_cfg == 0) chains = 1;
    else if (bucket_cfg > chm_pkg::MaxBuckets) chains = chm_pkg::MaxBuckets;
    else chains = 32'(bucket_cfg);
    bkt = key % chains;
    n = 32'(head_q[bkt]);
    p = chm_pkg::PoolEntries;
    steps = 0;
    while (n < chm_pkg::PoolEntries && steps < chm_pkg::PoolEntries && nkey_q[n] != key) begin
      p = n;
      n = 32'(nlink_q[n]);
      steps++;
    end
    if (!(n < chm_pkg::PoolEntries && steps < chm_pkg::PoolEntries)) n = chm_pkg::PoolEntries;
    r.status = chm_pkg::ST_NOTFOUND;
    r.found = '0;
    if (op == chm_pkg::OP_INSERT) begin
      if (n < chm_pkg::PoolEntries) begin
        r.status = chm_pkg::ST_DUP;
        r.found = nval_q[n];
      end else begin
        fresh = chm_pkg::PoolEntries;
        if (free_top > 0) begin
          free_top--;
          fresh = 32'(free_q[free_top]);
        end else if (fresh_mark < chm_pkg::PoolEntries) begin
          fresh = fresh_mark++;
        end
        if (fresh < chm_pkg::PoolEntries) begin
          nkey_q[fresh] = key;
          nval_q[fresh] = val;
          nlink_q[fresh] = head_q[bkt];
          head_q[bkt] = 9'(fresh);
          stored++;
          r.status = chm_pkg::ST_OK;
        end else begin
          r.status = chm_pkg::ST_FULL;
        end
      end
    end else if (op == chm_pkg::OP_LOOKUP && n < chm_pkg::PoolEntries) begin
      r.status = chm_pkg::ST_OK;
      r.found = nval_q[n];
    end else if (op == chm_pkg::OP_REMOVE && n < chm_pkg::PoolEntries) begin
      r.status = chm_pkg::ST_OK;
      r.found = nval_q[n];
      if (p < chm_pkg::PoolEntries) nlink_q[p] = nlink_q[n];
      else head_q[bkt] = nlink_q[n];
      if (free_top < chm_pkg::PoolEntries) free_q[free_top++] = 9'(n);
      if (stored > 0) stored--;
    end
    r.total = 9'(stored);
    return r;
  endfunction

  task automatic send_op(chm_pkg::op_e op, logic [30:0] key, logic [31:0] val, bit typed = 0,
                         map_result_t tres = '{default: '0});
    int unsigned gap;
    gap = $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pending_q.push_back(map_apply(op, key, val));
    typed_flag_q.push_back(typed);
    typed_q.push_back(tres);
    valid_i <= 1'b1;
    op_i <= op;
    key_i <= key;
    value_i <= val;
    do @(posedge clk_i); while (!ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic set_buckets(logic [8:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    bucket_cfg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (hold_off) ready_i <= 1'b0;
      else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (stall != 0) begin
          ready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        ready_i <= 1'b1;
        do @(posedge clk_i); while (!(valid_o && ready_i) && !hold_off);
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    map_result_t e;
    if (valid_o && ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%0h total=%0d", $realtime,
                 status_o, found_value_o, entry_total_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (typed_flag_q.pop_front()) e = typed_q.pop_front();
        else void'(typed_q.pop_front());
        if (status_o !== e.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.status, status_o);
          errors++;
        end
        if (found_value_o !== e.found) begin
          $display("%0t: found_value exp %0h got %0h", $realtime, e.found, found_value_o);
          errors++;
        end
        if (entry_total_o !== e.total) begin
          $display("%0t: entry_total exp %0d got %0d", $realtime, e.total, entry_total_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    map_row_t rows[$];
    chm_pkg::op_e ops[3];
    int unsigned keyspace, i, k;
    logic [30:0] key;
    foreach (head_q[j]) head_q[j] = 9'(chm_pkg::PoolEntries);
    free_top = 0; fresh_mark = 0; stored = 0; bucket_cfg = 2;
    ops = '{chm_pkg::OP_INSERT, chm_pkg::OP_LOOKUP, chm_pkg::OP_REMOVE};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    rows = '{
      '{chm_pkg::OP_LOOKUP, 31'd5, 32'd0, 1, '{chm_pkg::ST_NOTFOUND, 32'd0, 9'd0}},
      '{chm_pkg::OP_REMOVE, 31'h7fffffff, 32'd0, 1, '{chm_pkg::ST_NOTFOUND, 32'd0, 9'd0}},
      '{chm_pkg::OP_INSERT, 31'd0, 32'hffffffff, 1, '{chm_pkg::ST_OK, 32'd0, 9'd1}},
      '{chm_pkg::OP_INSERT, 31'h7fffffff, 32'd1, 1, '{chm_pkg::ST_OK, 32'd0, 9'd2}},
      '{chm_pkg::OP_INSERT, 31'd2, 32'd0, 1, '{chm_pkg::ST_OK, 32'd0, 9'd3}},
      '{chm_pkg::OP_INSERT, 31'd0, 32'd7, 1, '{chm_pkg::ST_DUP, 32'hffffffff, 9'd3}},
      '{chm_pkg::OP_LOOKUP, 31'd2, 32'd9, 1, '{chm_pkg::ST_OK, 32'd0, 9'd3}},
      '{chm_pkg::OP_LOOKUP, 31'h7fffffff, 32'd0, 1, '{chm_pkg::ST_OK, 32'd1, 9'd3}},
      '{chm_pkg::OP_NONE, 31'd0, 32'd0, 1, '{chm_pkg::ST_NOTFOUND, 32'd0, 9'd3}},
      '{chm_pkg::OP_REMOVE, 31'd0, 32'd0, 1, '{chm_pkg::ST_OK, 32'hffffffff, 9'd2}},
      '{chm_pkg::OP_LOOKUP, 31'd0, 32'd0, 1, '{chm_pkg::ST_NOTFOUND, 32'd0, 9'd2}},
      '{chm_pkg::OP_REMOVE, 31'd2, 32'd0, 1, '{chm_pkg::ST_OK, 32'd0, 9'd1}},
      '{chm_pkg::OP_INSERT, 31'd4, 32'h12345678, 0, '{default: '0}},
      '{chm_pkg::OP_INSERT, 31'd6, 32'h55aa55aa, 0, '{default: '0}},
      '{chm_pkg::OP_REMOVE, 31'd4, 32'd0, 0, '{default: '0}}
    };
    foreach (rows[r]) send_op(rows[r].op, rows[r].key, rows[r].value, rows[r].typed,
                              rows[r].res);

    // rehash hazard: change modulo with entries stored
    set_buckets(9'd0);
    send_op(chm_pkg::OP_LOOKUP, 31'd6, 32'd0);
    send_op(chm_pkg::OP_INSERT, 31'd8, 32'hdeadbeef);
    set_buckets(9'd511);
    send_op(chm_pkg::OP_LOOKUP, 31'd8, 32'd0);
    send_op(chm_pkg::OP_INSERT, 31'd6, 32'd3);

    // fill the pool to reach the full case, with a long receiver stall
    set_buckets(9'd256);
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (i = 0; i < 262; i++) send_op(chm_pkg::OP_INSERT, 31'(1000 + i * 7), $urandom);
    join
    for (i = 0; i < 262; i++) send_op(chm_pkg::OP_REMOVE, 31'(1000 + i * 7), 32'd0);

    // random phases over several bucket counts
    for (k = 0; k < 6; k++) begin
      case (k)
        0: set_buckets(9'd1);
        1: set_buckets(9'd256);
        2: set_buckets(9'($urandom_range(2, 255)));
        3: set_buckets(9'd3);
        4: set_buckets(9'($urandom_range(257, 511)));
        default: set_buckets(9'd2);
      endcase
      keyspace = (k == 4) ? 400 : 48;
      for (i = 0; i < 110; i++) begin
        if ($urandom_range(0, 9) == 0) key = 31'($urandom);
        else key = 31'($urandom_range(0, keyspace)) ^ (k[0] ? 31'h7fffff00 : 31'd0);
        if ($urandom_range(0, 39) == 0) send_op(chm_pkg::OP_NONE, key, $urandom);
        else send_op(ops[$urandom_range(0, 2)], key, $urandom);
      end
    end
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
src/chm_pkg.sv
src/chm_ram.sv
src/chm_front.sv
src/chm_queue.sv
src/chm_back.sv
src/chained_hash_map.sv
tb/tb_top.sv
